// ----- sv/rpn_pkg.sv -----
// RPN calculator package: payload structs, token codes, controller/datapath bundles.
// No dependencies.
`timescale 1ns / 1ps
package rpn_pkg;
	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_ADD = 3'd1;
	localparam logic [2:0] OP_SUB = 3'd2;
	localparam logic [2:0] OP_MUL = 3'd3;
	localparam logic [2:0] OP_DIV = 3'd4;
	localparam logic [2:0] OP_MOD = 3'd5;
	localparam logic [2:0] OP_PRINT = 3'd6;
	localparam logic [2:0] OP_UNKNOWN = 3'd7;

	typedef struct packed {
		logic [2:0] op;
		logic signed [31:0] value;
	} rpn_in_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic printed;
		logic stack_full_error;
		logic stack_empty_error;
		logic zero_divisor_error;
		logic unknown_command_error;
	} rpn_out_t;

	// controller -> datapath
	typedef struct packed {
		logic load_tok;   // latch token
		logic rd_b;       // read top into b
		logic rd_a;       // read next into a
		logic cap_b;      // capture read data as b
		logic cap_a;      // capture read data as a
		logic mul_go;     // multiply stage 1
		logic mul_fin;    // multiply stage 2 (scale+saturate)
		logic div_go;     // start divider
		logic wr_res;     // push computed result
		logic wr_val;     // push token value
		logic set_zdiv;
		logic set_print;
		logic set_unknown;
		logic clr_flags;
	} rpn_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_busy;
		logic b_zero;     // divisor zero for current op
	} rpn_stat_t;
endpackage

// ----- sv/rpn_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- sv/rpn_div.sv -----
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
// Depends on nothing; signs are handled by the caller.
`timescale 1ns / 1ps
module rpn_div #(
	parameter int NW = 48,
	parameter int DW = 32
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	output logic busy,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);
	localparam int CW = $clog2(NW + 1);
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW:0] rem_q;
	logic [DW-1:0] den_q;
	logic [DW:0] trial;

	assign trial = {rem_q[DW-1:0], quo_q[NW-1]} - {1'b0, den_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!trial[DW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-1:0], quo_q[NW-1]};
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end
	assign busy = (cnt_q != '0);
	assign quo = quo_q;
	assign rem = rem_q[DW-1:0];
endmodule

// ----- sv/rpn_dp.sv -----
// Datapath: operand stack RAM, stack pointer, operand registers, ALU, divider.
// Depends on rpn_pkg, rpn_ram, rpn_div.
`timescale 1ns / 1ps
module rpn_dp import rpn_pkg::*; #(
	parameter int STACK_DEPTH = 128,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input rpn_in_t tok,
	input rpn_cmd_t cmd,
	output rpn_stat_t stat,
	output rpn_out_t res
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int PW = $clog2(STACK_DEPTH + 1);
	localparam int NW = 32 + FRAC_BITS;
	localparam logic signed [63:0] MAXV = 64'sd2147483647;
	localparam logic signed [63:0] MINV = -64'sd2147483648;

	rpn_in_t tok_q;
	logic [PW-1:0] sp_q;
	logic signed [31:0] a_q, b_q, r_q;
	logic pend_a_q, pend_b_q;
	logic full_q, empty_q, zdiv_q, print_q, unk_q;
	logic signed [63:0] prod_s1;
	logic [AW-1:0] raddr;
	logic [31:0] rdata;
	logic we;
	logic [31:0] wdata;
	logic div_busy;
	logic [NW-1:0] dquo;
	logic [31:0] drem;
	logic [NW-1:0] dnum;
	logic [31:0] dden;
	logic neg_q;
	logic signed [31:0] ia, ib;
	logic signed [63:0] sum, dq, prod_sc;
	logic signed [32:0] m;
	logic signed [31:0] mres;

	rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(sp_q[AW-1:0]), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// integer parts, truncated toward zero; widen so the most negative value negates cleanly
	assign ia = (a_q < 0) ? 32'(-((-33'(a_q)) >>> FRAC_BITS)) : (a_q >>> FRAC_BITS);
	assign ib = (b_q < 0) ? 32'(-((-33'(b_q)) >>> FRAC_BITS)) : (b_q >>> FRAC_BITS);
	assign raddr = AW'(sp_q - 1'b1);

	always_comb begin
		dnum = (tok_q.op == OP_DIV)
			? NW'((a_q < 0) ? -64'(a_q) : 64'(a_q)) << FRAC_BITS
			: NW'((ia < 0) ? -64'(ia) : 64'(ia));
		dden = (tok_q.op == OP_DIV) ? ((b_q < 0) ? 32'(-b_q) : 32'(b_q))
			: ((ib < 0) ? 32'(-ib) : 32'(ib));
		stat.b_zero = (tok_q.op == OP_DIV) ? (b_q == 0) : (ib == 0);
		stat.div_busy = div_busy;
	end

	rpn_div #(.NW(NW), .DW(32)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_go), .num(dnum), .den(dden),
		.busy(div_busy), .quo(dquo), .rem(drem)
	);

	always_comb begin
		sum = '0;
		mres = '0;
		prod_sc = (prod_s1 < 0) ? -((-prod_s1) >>> FRAC_BITS) : (prod_s1 >>> FRAC_BITS);
		dq = neg_q ? -$signed({1'b0, 63'(dquo)}) : $signed({1'b0, 63'(dquo)});
		// C remainder takes the dividend sign; a negative divisor moves a positive
		// remainder into the divisor's range
		m = (ia < 0) ? -$signed({1'b0, drem}) : $signed({1'b0, drem});
		if (b_q < 0 && m > 0) begin
			m = m + 33'(ib);
		end
		mres = 32'(m);
		unique case (tok_q.op)
			OP_ADD: sum = 64'(a_q) + 64'(b_q);
			OP_SUB: sum = 64'(a_q) - 64'(b_q);
			OP_MUL: sum = prod_sc;
			OP_DIV: sum = dq;
			default: sum = 64'(mres) <<< FRAC_BITS;
		endcase
		if (sum > MAXV) begin
			wdata = 32'h7fffffff;
		end else if (sum < MINV) begin
			wdata = 32'h80000000;
		end else begin
			wdata = sum[31:0];
		end
		if (cmd.wr_val) begin
			wdata = tok_q.value;
		end
	end

	assign we = (cmd.wr_res || cmd.wr_val) && (sp_q < PW'(STACK_DEPTH));

	always_ff @(posedge clk) begin
		if (cmd.load_tok) begin
			tok_q <= tok;
		end
		if (cmd.mul_go) begin
			prod_s1 <= 64'(a_q) * 64'(b_q);
		end
		if (cmd.div_go) begin
			neg_q <= (a_q < 0) ^ (b_q < 0);
		end
		if (cmd.cap_b) begin
			b_q <= pend_b_q ? rdata : '0;
		end
		if (cmd.cap_a) begin
			a_q <= pend_a_q ? rdata : '0;
		end
		if (cmd.load_tok) begin
			r_q <= '0;
		end else if (cmd.set_print) begin
			r_q <= pend_b_q ? rdata : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			pend_a_q <= 1'b0;
			pend_b_q <= 1'b0;
			full_q <= 1'b0;
			empty_q <= 1'b0;
			zdiv_q <= 1'b0;
			print_q <= 1'b0;
			unk_q <= 1'b0;
		end else begin
			if (cmd.clr_flags) begin
				full_q <= 1'b0;
				empty_q <= 1'b0;
				zdiv_q <= 1'b0;
				print_q <= 1'b0;
				unk_q <= 1'b0;
			end
			if (cmd.rd_b) begin
				pend_b_q <= (sp_q != '0);
				if (sp_q != '0) begin
					sp_q <= sp_q - 1'b1;
				end else begin
					empty_q <= 1'b1;
				end
			end
			if (cmd.rd_a) begin
				pend_a_q <= (sp_q != '0);
				if (sp_q != '0) begin
					sp_q <= sp_q - 1'b1;
				end else begin
					empty_q <= 1'b1;
				end
			end
			if (cmd.wr_res || cmd.wr_val) begin
				if (we) begin
					sp_q <= sp_q + 1'b1;
				end else begin
					full_q <= 1'b1;
				end
			end
			if (cmd.set_zdiv) begin
				zdiv_q <= 1'b1;
			end
			if (cmd.set_print) begin
				print_q <= 1'b1;
			end
			if (cmd.set_unknown) begin
				unk_q <= 1'b1;
			end
		end
	end

	always_comb begin
		res.result = r_q;
		res.printed = print_q;
		res.stack_full_error = full_q;
		res.stack_empty_error = empty_q;
		res.zero_divisor_error = zdiv_q;
		res.unknown_command_error = unk_q;
	end
endmodule

// ----- sv/rpn_ctrl.sv -----
// Controller FSM: sequences stack reads, arithmetic and writes per token.
// Depends on rpn_pkg.
`timescale 1ns / 1ps
module rpn_ctrl import rpn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic [2:0] in_op,
	input logic out_taken,
	input rpn_stat_t stat,
	output rpn_cmd_t cmd,
	output logic idle,
	output logic out_valid
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC = 4'd1;
	localparam logic [3:0] S_CB = 4'd2;
	localparam logic [3:0] S_RA = 4'd3;
	localparam logic [3:0] S_CA = 4'd4;
	localparam logic [3:0] S_EXE = 4'd5;
	localparam logic [3:0] S_MUL = 4'd6;
	localparam logic [3:0] S_DIVW = 4'd7;
	localparam logic [3:0] S_WR = 4'd8;
	localparam logic [3:0] S_PR = 4'd9;
	localparam logic [3:0] S_OUT = 4'd10;
	localparam logic [3:0] S_ZCHK = 4'd11;

	logic [3:0] state_q, state_d;
	logic [2:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_PUSH;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				op_q <= in_op;
			end
		end
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load_tok = 1'b1;
					cmd.clr_flags = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				case (op_q)
					OP_PUSH: begin
						cmd.wr_val = 1'b1;
						state_d = S_OUT;
					end
					OP_UNKNOWN: begin
						cmd.set_unknown = 1'b1;
						state_d = S_OUT;
					end
					OP_PRINT: begin
						cmd.rd_b = 1'b1;
						state_d = S_PR;
					end
					default: begin
						cmd.rd_b = 1'b1;
						state_d = S_CB;
					end
				endcase
			end
			S_PR: begin
				cmd.set_print = 1'b1;
				state_d = S_OUT;
			end
			S_CB: begin
				cmd.cap_b = 1'b1;
				state_d = (op_q == OP_DIV || op_q == OP_MOD) ? S_ZCHK : S_RA;
			end
			S_ZCHK: begin
				if (stat.b_zero) begin
					cmd.set_zdiv = 1'b1;
					state_d = S_OUT;
				end else begin
					state_d = S_RA;
				end
			end
			S_RA: begin
				cmd.rd_a = 1'b1;
				state_d = S_CA;
			end
			S_CA: begin
				cmd.cap_a = 1'b1;
				state_d = S_EXE;
			end
			S_EXE: begin
				case (op_q)
					OP_MUL: begin
						cmd.mul_go = 1'b1;
						state_d = S_MUL;
					end
					OP_DIV, OP_MOD: begin
						cmd.div_go = 1'b1;
						state_d = S_DIVW;
					end
					default: begin
						cmd.wr_res = 1'b1;
						state_d = S_OUT;
					end
				endcase
			end
			S_MUL: begin
				cmd.mul_fin = 1'b1;
				state_d = S_WR;
			end
			S_DIVW: begin
				if (!stat.div_busy) begin
					state_d = S_WR;
				end
			end
			S_WR: begin
				cmd.wr_res = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_taken) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign idle = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
endmodule

// ----- sv/rpn_stack_calculator.sv -----
// Top level of the RPN stack calculator: handshakes, controller and datapath.
// Depends on rpn_pkg, rpn_ctrl, rpn_dp.
//
// channel | signals                  | payload
// in      | in_valid / in_ready      | rpn_in_t  (op, value)
// out     | out_valid / out_ready    | rpn_out_t (result and flags)
//
// One token at a time; div/mod wait for the one-bit-per-cycle divider.
// Reset clears the stack pointer and control; stack contents are
// undefined until pushed. A stalled result holds in the output
// register and blocks the next token.
`timescale 1ns / 1ps
module rpn_stack_calculator import rpn_pkg::*; #(
	parameter int STACK_DEPTH = 128,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input rpn_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output rpn_out_t out_data
);
	rpn_cmd_t cmd;
	rpn_stat_t stat;
	logic idle;

	rpn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_valid && in_ready),
		.in_op(in_data.op), .out_taken(out_ready), .stat(stat), .cmd(cmd),
		.idle(idle), .out_valid(out_valid)
	);

	rpn_dp #(.STACK_DEPTH(STACK_DEPTH), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .tok(in_data), .cmd(cmd), .stat(stat),
		.res(out_data)
	);

	assign in_ready = idle;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input accepted while result pending");
	a_print_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.printed |-> out_data.result == '0)
		else $error("nonzero result without print");
	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready) else $error("no return to idle");
endmodule

// ----- tb/rpn_stack_calculator_tb.sv -----
// Testbench for rpn_stack_calculator: directed and random token streams checked against
// a local stack predictor. Depends on rpn_pkg and rpn_stack_calculator.
`timescale 1ns / 1ps
module rpn_stack_calculator_tb;
	import rpn_pkg::*;

	localparam int DEPTH = 128;
	localparam int FRAC = 16;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	rpn_in_t in_data;
	logic out_valid;
	logic out_ready;
	rpn_out_t out_data;

	rpn_stack_calculator #(.STACK_DEPTH(DEPTH), .FRAC_BITS(FRAC)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// predictor state
	logic signed [31:0] calc_stack [DEPTH];
	int calc_depth = 0;

	rpn_in_t token_queue[$];
	int pause_marks[$];      // token index before which the sender drains
	rpn_out_t expected_results[$];
	int n_sent = 0;
	int n_errors = 0;
	bit stim_done;
	int hold_off_at;         // result count at which the receiver holds off long
	int n_results = 0;

	always #10 clk = ~clk;

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return 32'sh7fffffff;
		if (x < -64'sd2147483648)
			return 32'sh80000000;
		return x[31:0];
	endfunction

	function automatic rpn_out_t evaluate_token(input rpn_in_t tok);
		rpn_out_t r;
		logic signed [63:0] a, b, ia, ib, m, num;
		r = '0;
		case (tok.op)
			OP_PUSH: begin
				if (calc_depth < DEPTH) begin
					calc_stack[calc_depth] = tok.value;
					calc_depth++;
				end else
					r.stack_full_error = 1'b1;
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_PRINT: begin
				if (calc_depth > 0) begin
					calc_depth--;
					b = calc_stack[calc_depth];
				end else begin
					b = 0;
					r.stack_empty_error = 1'b1;
				end
				ib = b / (64'sd1 <<< FRAC);
				if (tok.op == OP_PRINT) begin
					r.result = b[31:0];
					r.printed = 1'b1;
				end else if ((tok.op == OP_DIV && b == 0) || (tok.op == OP_MOD && ib == 0)) begin
					r.zero_divisor_error = 1'b1;
				end else begin
					if (calc_depth > 0) begin
						calc_depth--;
						a = calc_stack[calc_depth];
					end else begin
						a = 0;
						r.stack_empty_error = 1'b1;
					end
					case (tok.op)
						OP_ADD: num = clamp32(a + b);
						OP_SUB: num = clamp32(a - b);
						OP_MUL: num = clamp32((a * b) / (64'sd1 <<< FRAC));
						OP_DIV: num = clamp32((a * (64'sd1 <<< FRAC)) / b);
						default: begin
							ia = a / (64'sd1 <<< FRAC);
							m = ia % ib;
							if (b <= 0)
								m = (m + ib) % ib;
							num = clamp32(m * (64'sd1 <<< FRAC));
						end
					endcase
					// push back the result; a slot is always free after two pops
					if (calc_depth < DEPTH) begin
						calc_stack[calc_depth] = num[31:0];
						calc_depth++;
					end else
						r.stack_full_error = 1'b1;
				end
			end
			default: r.unknown_command_error = 1'b1;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff - $urandom_range(0, 3);
			1: return 32'sh80000000 + $urandom_range(0, 3);
			2: return $signed($urandom_range(0, 40) - 20) <<< FRAC;
			3: return $signed($urandom_range(0, 1)) - 0;
			default: return $urandom();
		endcase
	endfunction

	task automatic add_token(input logic [2:0] op, input logic signed [31:0] v);
		rpn_in_t t;
		t.op = op;
		t.value = v;
		token_queue.push_back(t);
	endtask

	// driver
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
		end else if (in_valid && !in_ready) begin
			// hold the pending transaction
		end else begin
			if (in_valid) begin
				expected_results.push_back(evaluate_token(in_data));
				n_sent = n_sent + 1;
			end
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pause_marks.size() > 0 && pause_marks[0] == n_sent &&
					!(in_valid == 1'b0 && expected_results.size() == 0)) begin
				in_valid <= 1'b0;
			end else if (token_queue.size() > 0) begin
				if (pause_marks.size() > 0 && pause_marks[0] == n_sent)
					void'(pause_marks.pop_front());
				in_data <= token_queue.pop_front();
				in_valid <= 1'b1;
				send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			end else begin
				in_valid <= 1'b0;
				if (stim_done)
					send_gap <= 0;
			end
		end
	end

	// monitor and receiver stalls
	int recv_wait;
	bit long_hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait <= 0;
			long_hold_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				rpn_out_t exp_r;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, out_data);
					n_errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r.result !== out_data.result)
						$display("%0t: result exp %h act %h", $time, exp_r.result,
							out_data.result);
					if (exp_r.printed !== out_data.printed)
						$display("%0t: printed exp %b act %b", $time, exp_r.printed,
							out_data.printed);
					if (exp_r.stack_full_error !== out_data.stack_full_error)
						$display("%0t: stack_full_error exp %b act %b", $time,
							exp_r.stack_full_error, out_data.stack_full_error);
					if (exp_r.stack_empty_error !== out_data.stack_empty_error)
						$display("%0t: stack_empty_error exp %b act %b", $time,
							exp_r.stack_empty_error, out_data.stack_empty_error);
					if (exp_r.zero_divisor_error !== out_data.zero_divisor_error)
						$display("%0t: zero_divisor_error exp %b act %b", $time,
							exp_r.zero_divisor_error, out_data.zero_divisor_error);
					if (exp_r.unknown_command_error !== out_data.unknown_command_error)
						$display("%0t: unknown_command_error exp %b act %b", $time,
							exp_r.unknown_command_error, out_data.unknown_command_error);
					if (exp_r !== out_data)
						n_errors++;
				end
				n_results++;
			end
			if (!long_hold_done && n_results == hold_off_at) begin
				// long hold-off: sender keeps offering, the block stalls its input
				out_ready <= 1'b0;
				recv_wait <= 400;
				long_hold_done <= 1'b1;
			end else if (recv_wait > 0) begin
				out_ready <= 1'b0;
				recv_wait <= recv_wait - 1;
			end else if (out_valid && out_ready) begin
				recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	initial begin
		#50_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int i, k, op_sel, seq_len;
		clk = 1'b0;
		arst_n = 1'b0;
		stim_done = 1'b0;
		hold_off_at = 300;

		// directed: empty pops, every operator, extremes, zero divisors
		add_token(OP_PRINT, 0);
		add_token(OP_ADD, 0);
		add_token(OP_UNKNOWN, 32'sh5a5a5a5a);
		add_token(OP_PUSH, 32'sh7fffffff);
		add_token(OP_PUSH, 32'sh7fffffff);
		add_token(OP_ADD, 0);
		add_token(OP_PUSH, 32'sh80000000);
		add_token(OP_SUB, 0);
		add_token(OP_PUSH, 32'sh80000000);
		add_token(OP_MUL, 0);
		add_token(OP_PUSH, 32'sh00008000);
		add_token(OP_DIV, 0);
		add_token(OP_PUSH, 0);
		add_token(OP_DIV, 0);
		add_token(OP_PUSH, 32'sh0000ffff);
		add_token(OP_MOD, 0);
		add_token(OP_PUSH, -(32'sd7 <<< FRAC));
		add_token(OP_PUSH, -(32'sd3 <<< FRAC));
		add_token(OP_MOD, 0);
		add_token(OP_PUSH, 32'sd5 <<< FRAC);
		add_token(OP_MOD, 0);
		add_token(OP_PRINT, 0);
		add_token(OP_PRINT, 0);
		// fill to overflow and drain past empty
		for (i = 0; i < DEPTH + 3; i++)
			add_token(OP_PUSH, rand_value());
		pause_marks.push_back(token_queue.size());
		for (i = 0; i < DEPTH + 2; i++)
			add_token(($urandom_range(0, 7) == 0) ? OP_ADD : OP_PRINT, 0);

		// random: mostly well-formed expressions, some noise
		while (token_queue.size() < 1800) begin
			if ($urandom_range(0, 4) == 0) begin
				add_token(3'($urandom_range(0, 7)), $urandom());
			end else begin
				seq_len = $urandom_range(1, 6);
				add_token(OP_PUSH, rand_value());
				for (k = 0; k < seq_len; k++) begin
					add_token(OP_PUSH, rand_value());
					op_sel = $urandom_range(1, 5);
					add_token(op_sel[2:0], $urandom());
				end
				add_token(OP_PRINT, $urandom());
			end
			if (token_queue.size() > 900 && pause_marks.size() < 2)
				pause_marks.push_back(token_queue.size());
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		stim_done = 1'b1;
		wait (token_queue.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (200) @(posedge clk);
		if (n_errors == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
